// ===== design/rtfe_pkg.sv =====
`default_nettype none
package rtfe_pkg;

    localparam int BYTES_PER_WORD_DEF = 8;
    localparam int MAX_WORD_BYTES     = 8;
    localparam int HDR_LEN            = 72;
    localparam int LEN_W              = 7;
    localparam int SMALL_BYTES        = 25;
    localparam int SMALL_BITS         = SMALL_BYTES * 8;
    localparam int BCD_W              = 20;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_STYLE = 2'd1,
        REQ_CHAR  = 2'd2,
        REQ_END   = 2'd3
    } req_kind_t;

    // One input transaction on its way through the digit conversion
    typedef struct packed {
        req_kind_t        kind;
        logic [15:0]      code_unit;
        logic [3:0]       style;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } item_t;

    // Formatted bytes of one transaction, first byte in the low bits
    typedef struct packed {
        logic                  hdr;
        logic [LEN_W-1:0]      len;
        logic [SMALL_BITS-1:0] text;
    } frag_t;

endpackage
`default_nettype wire

// ===== design/rtfe_front.sv =====
`default_nettype none
module rtfe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_type,
    input  logic [15:0]         code_unit,
    input  logic                bold_on,
    input  logic                italic_on,
    input  logic                underline_on,
    input  logic                strike_on,
    output logic                item_valid,
    output rtfe_pkg::item_t     item,
    input  logic                item_take
);
    import rtfe_pkg::*;

    // One double-dabble step: adjust every digit, then shift in the next bit
    function automatic logic [BCD_W-1:0] dd_shift(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] t;
        t = bcd;
        for (int d = 0; d < BCD_W / 4; d++) begin
            if (t[4*d +: 4] >= 4'd5) begin
                t[4*d +: 4] = t[4*d +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], b};
    endfunction

    logic  s1_valid_reg;
    logic  s2_valid_reg;
    item_t s1_reg;
    item_t s2_reg;
    item_t s1_next;
    item_t s2_next;
    logic  s1_ready;
    logic  s2_ready;
    logic [15:0] mag_in;
    logic [7:0]  mag_lo;

    assign s2_ready  = !s2_valid_reg || item_take;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_ready = s1_ready;

    // High byte of the magnitude on the way in
    always_comb
    begin
        mag_in            = code_unit[15] ? 16'(~code_unit + 16'd1) : code_unit;
        s1_next.kind      = req_kind_t'(req_type);
        s1_next.code_unit = code_unit;
        s1_next.style     = {strike_on, underline_on, italic_on, bold_on};
        s1_next.neg       = code_unit[15];
        s1_next.bcd       = '0;
        for (int k = 15; k >= 8; k--) begin
            s1_next.bcd = dd_shift(s1_next.bcd, mag_in[k]);
        end
    end

    // Low byte finishes the decimal digits
    always_comb
    begin
        mag_lo  = s1_reg.neg ? 8'(~s1_reg.code_unit[7:0] + 8'd1) : s1_reg.code_unit[7:0];
        s2_next = s1_reg;
        for (int k = 7; k >= 0; k--) begin
            s2_next.bcd = dd_shift(s2_next.bcd, mag_lo[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_reg;

endmodule
`default_nettype wire

// ===== design/rtfe_format.sv =====
`default_nettype none
module rtfe_format (
    input  logic            clk,
    input  logic            rst_n,
    input  rtfe_pkg::item_t item,
    input  logic            item_fire,
    output rtfe_pkg::frag_t frag
);
    import rtfe_pkg::*;

    localparam logic [15:0] CU_TAB     = 16'h0009;
    localparam logic [15:0] CU_LF      = 16'h000A;
    localparam logic [15:0] CU_BSLASH  = 16'h005C;
    localparam logic [15:0] CU_LBRACE  = 16'h007B;
    localparam logic [15:0] CU_RBRACE  = 16'h007D;
    localparam logic [15:0] FIRST_PRINTABLE = 16'h0020;
    localparam logic [15:0] LAST_PRINTABLE  = 16'h007E;
    localparam logic [15:0] FIRST_WIDE      = 16'h0080;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [15:0] ESC_BSLASH = 16'h5C5C;
    localparam logic [15:0] ESC_LBRACE = 16'h7B5C;
    localparam logic [15:0] ESC_RBRACE = 16'h7D5C;
    localparam logic [39:0] ESC_PAR    = 40'h0A7261705C;
    localparam logic [39:0] ESC_TAB    = 40'h206261745C;

    // Control words, order bold, italic, underline, strike
    localparam logic [71:0] STYLE_ON [4] = '{
        72'h20625C, 72'h20695C, 72'h206C755C, 72'h20656B697274735C
    };
    localparam int STYLE_ON_LEN [4] = '{3, 3, 4, 8};
    localparam logic [71:0] STYLE_OFF [4] = '{
        72'h2030625C, 72'h2030695C, 72'h20656E6F6E6C755C, 72'h2030656B697274735C
    };
    localparam int STYLE_OFF_LEN [4] = '{4, 4, 8, 9};

    logic [3:0] prev_style_reg;
    logic [3:0] prev_style_next;
    logic [2:0] nd;
    logic [3:0] dig [5];

    always_comb
    begin
        for (int k = 0; k < 5; k++) begin
            dig[k] = item.bcd[4*k +: 4];
        end
        if (dig[4] != 4'd0)
            nd = 3'd5;
        else if (dig[3] != 4'd0)
            nd = 3'd4;
        else if (dig[2] != 4'd0)
            nd = 3'd3;
        else if (dig[1] != 4'd0)
            nd = 3'd2;
        else
            nd = 3'd1;
    end

    always_comb
    begin
        frag.hdr        = 1'b0;
        frag.len        = '0;
        frag.text       = '0;
        prev_style_next = prev_style_reg;
        case (item.kind)
            REQ_BEGIN:
            begin
                frag.hdr        = 1'b1;
                frag.len        = LEN_W'(HDR_LEN);
                prev_style_next = 4'd0;
            end
            REQ_STYLE:
            begin
                // Prepend from strike down to bold so bold lands first
                for (int i = 3; i >= 0; i--) begin
                    if (item.style[i] != prev_style_reg[i])
                    begin
                        if (item.style[i])
                        begin
                            frag.text = (frag.text << (8 * STYLE_ON_LEN[i]))
                                        | SMALL_BITS'(STYLE_ON[i]);
                            frag.len  = frag.len + LEN_W'(STYLE_ON_LEN[i]);
                        end
                        else
                        begin
                            frag.text = (frag.text << (8 * STYLE_OFF_LEN[i]))
                                        | SMALL_BITS'(STYLE_OFF[i]);
                            frag.len  = frag.len + LEN_W'(STYLE_OFF_LEN[i]);
                        end
                    end
                end
                prev_style_next = item.style;
            end
            REQ_CHAR:
            begin
                case (item.code_unit)
                    CU_BSLASH:
                    begin
                        frag.text = SMALL_BITS'(ESC_BSLASH);
                        frag.len  = LEN_W'(2);
                    end
                    CU_LBRACE:
                    begin
                        frag.text = SMALL_BITS'(ESC_LBRACE);
                        frag.len  = LEN_W'(2);
                    end
                    CU_RBRACE:
                    begin
                        frag.text = SMALL_BITS'(ESC_RBRACE);
                        frag.len  = LEN_W'(2);
                    end
                    CU_LF:
                    begin
                        frag.text = SMALL_BITS'(ESC_PAR);
                        frag.len  = LEN_W'(5);
                    end
                    CU_TAB:
                    begin
                        frag.text = SMALL_BITS'(ESC_TAB);
                        frag.len  = LEN_W'(5);
                    end
                    default:
                    begin
                        if (item.code_unit >= FIRST_PRINTABLE &&
                            item.code_unit <= LAST_PRINTABLE)
                        begin
                            frag.text = SMALL_BITS'(item.code_unit[7:0]);
                            frag.len  = LEN_W'(1);
                        end
                        else if (item.code_unit >= FIRST_WIDE)
                        begin
                            // Build \u[-]digits? back to front
                            frag.text = SMALL_BITS'(CH_QMARK);
                            for (int k = 0; k < 5; k++) begin
                                if (3'(k) < nd)
                                begin
                                    frag.text = (frag.text << 8)
                                                | SMALL_BITS'(CH_ZERO | {4'd0, dig[k]});
                                end
                            end
                            if (item.neg)
                            begin
                                frag.text = (frag.text << 8) | SMALL_BITS'(CH_MINUS);
                            end
                            frag.text = (frag.text << 8) | SMALL_BITS'(CH_U);
                            frag.text = (frag.text << 8) | SMALL_BITS'(CH_BSLASH);
                            frag.len  = LEN_W'(3) + LEN_W'(item.neg) + LEN_W'(nd);
                        end
                    end
                endcase
            end
            REQ_END:
            begin
                frag.text = SMALL_BITS'(CH_RBRACE);
                frag.len  = LEN_W'(1);
            end
            default:
            begin
                frag.len = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_style_reg <= 4'd0;
        end
        else if (item_fire)
        begin
            prev_style_reg <= prev_style_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/rtfe_packer.sv =====
`default_nettype none
module rtfe_packer #(
    parameter int BYTES_PER_WORD = rtfe_pkg::BYTES_PER_WORD_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            frag_valid,
    input  rtfe_pkg::frag_t frag,
    output logic            frag_take,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [63:0]     out_bytes,
    output logic [3:0]      byte_count,
    output logic            last_of_item
);
    import rtfe_pkg::*;

    localparam logic [LEN_W-1:0] BPW_LEN = LEN_W'(BYTES_PER_WORD);

    localparam logic [7:0] HDR_ROM [HDR_LEN] = '{
        8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66, 8'h31, 8'h5C, 8'h61, 8'h6E, 8'h73, 8'h69, 8'h5C,
        8'h64, 8'h65, 8'h66, 8'h66, 8'h30, 8'h7B, 8'h5C, 8'h66, 8'h6F, 8'h6E, 8'h74, 8'h74,
        8'h62, 8'h6C, 8'h7B, 8'h5C, 8'h66, 8'h30, 8'h5C, 8'h66, 8'h6E, 8'h69, 8'h6C, 8'h20,
        8'h53, 8'h65, 8'h67, 8'h6F, 8'h65, 8'h20, 8'h55, 8'h49, 8'h3B, 8'h7D, 8'h7D, 8'h7B,
        8'h5C, 8'h63, 8'h6F, 8'h6C, 8'h6F, 8'h72, 8'h74, 8'h62, 8'h6C, 8'h20, 8'h3B, 8'h7D,
        8'h5C, 8'h70, 8'h61, 8'h72, 8'h64, 8'h5C, 8'h70, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h20
    };

    logic                  busy_reg;
    logic                  hdr_reg;
    logic [LEN_W-1:0]      pos_reg;
    logic [LEN_W-1:0]      rem_reg;
    logic [SMALL_BITS-1:0] text_reg;
    logic                  res_valid_reg;
    logic [63:0]           out_bytes_reg;
    logic [3:0]            byte_count_reg;
    logic                  last_reg;

    logic                  out_open;
    logic                  emit;
    logic                  is_last;
    logic                  load;
    logic [LEN_W-1:0]      cnt;
    logic [LEN_W-1:0]      idx;
    logic [63:0]           word;

    assign out_open  = !res_valid_reg || res_ready;
    assign emit      = busy_reg && out_open;
    assign is_last   = rem_reg <= BPW_LEN;
    assign cnt       = is_last ? rem_reg : BPW_LEN;
    assign frag_take = !busy_reg || (emit && is_last);
    // Drop transactions that format to no bytes
    assign load      = frag_take && frag_valid && (frag.len != '0);

    always_comb
    begin
        word = '0;
        idx  = '0;
        for (int i = 0; i < MAX_WORD_BYTES; i++) begin
            idx = pos_reg + LEN_W'(i);
            if (i < BYTES_PER_WORD && LEN_W'(i) < cnt)
            begin
                if (hdr_reg)
                begin
                    if (idx < LEN_W'(HDR_LEN))
                    begin
                        word[8*i +: 8] = HDR_ROM[idx];
                    end
                end
                else
                begin
                    word[8*i +: 8] = text_reg[8*i +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            hdr_reg       <= 1'b0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                hdr_reg  <= frag.hdr;
                pos_reg  <= '0;
                rem_reg  <= frag.len;
            end
            else if (emit)
            begin
                busy_reg <= !is_last;
                pos_reg  <= pos_reg + BPW_LEN;
                rem_reg  <= rem_reg - cnt;
            end
            if (out_open)
            begin
                res_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            text_reg <= frag.text;
        end
        else if (emit)
        begin
            text_reg <= text_reg >> (8 * BYTES_PER_WORD);
        end
        if (emit)
        begin
            out_bytes_reg  <= word;
            byte_count_reg <= cnt[3:0];
            last_reg       <= is_last;
        end
    end

    assign res_valid    = res_valid_reg;
    assign out_bytes    = out_bytes_reg;
    assign byte_count   = byte_count_reg;
    assign last_of_item = last_reg;

endmodule
`default_nettype wire

// ===== design/rtf_styled_text_encoder_top.sv =====
`default_nettype none
// Throughput: one result word per cycle while res_ready allows. A transaction of n bytes
// leaves the word packer as ceil(n / BYTES_PER_WORD) words, so one-word transactions go
// back to back and a header is ceil(72 / BYTES_PER_WORD) words. The packer sets the sustained rate.
// Reset: clears all valid flags and the remembered style (all flags off).
module rtf_styled_text_encoder_top #(
    parameter int BYTES_PER_WORD = rtfe_pkg::BYTES_PER_WORD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] code_unit,
    input  logic        bold_on,
    input  logic        italic_on,
    input  logic        underline_on,
    input  logic        strike_on,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [63:0] out_bytes,
    output logic [3:0]  byte_count,
    output logic        last_of_item
);
    import rtfe_pkg::*;

    item_t item;
    frag_t frag;
    logic  item_valid;
    logic  frag_take;
    logic  item_fire;

    assign item_fire = item_valid && frag_take;

    rtfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .code_unit    (code_unit),
        .bold_on      (bold_on),
        .italic_on    (italic_on),
        .underline_on (underline_on),
        .strike_on    (strike_on),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (frag_take)
    );

    rtfe_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .item_fire (item_fire),
        .frag      (frag)
    );

    rtfe_packer #(
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .frag_valid   (item_valid),
        .frag         (frag),
        .frag_take    (frag_take),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_bytes    (out_bytes),
        .byte_count   (byte_count),
        .last_of_item (last_of_item)
    );

endmodule
`default_nettype wire

// ===== test/rtf_byte_stream_checker.sv =====
module rtf_byte_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] code_unit,
    input  logic        bold_on,
    input  logic        italic_on,
    input  logic        underline_on,
    input  logic        strike_on,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [63:0] out_bytes,
    input  logic [3:0]  byte_count,
    input  logic        last_of_item,
    output int          errors,
    output int          words_waiting,
    output int          words_checked
);
    import rtfe_pkg::*;

    localparam int WORD_BYTES = 8;

    localparam logic [0:71][7:0] HEADER_ROM = {
        8'h7B, 8'h5C, 8'h72, 8'h74, 8'h66, 8'h31, 8'h5C, 8'h61, 8'h6E, 8'h73, 8'h69, 8'h5C,
        8'h64, 8'h65, 8'h66, 8'h66, 8'h30, 8'h7B, 8'h5C, 8'h66, 8'h6F, 8'h6E, 8'h74, 8'h74,
        8'h62, 8'h6C, 8'h7B, 8'h5C, 8'h66, 8'h30, 8'h5C, 8'h66, 8'h6E, 8'h69, 8'h6C, 8'h20,
        8'h53, 8'h65, 8'h67, 8'h6F, 8'h65, 8'h20, 8'h55, 8'h49, 8'h3B, 8'h7D, 8'h7D, 8'h7B,
        8'h5C, 8'h63, 8'h6F, 8'h6C, 8'h6F, 8'h72, 8'h74, 8'h62, 8'h6C, 8'h20, 8'h3B, 8'h7D,
        8'h5C, 8'h70, 8'h61, 8'h72, 8'h64, 8'h5C, 8'h70, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h20
    };

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } rtf_word_t;

    rtf_word_t   pending_words[$];
    logic [7:0]  item_bytes[$];
    logic [3:0]  run_style;
    rtf_word_t   oldest;
    logic [3:0]  new_style;
    int          err_count = 0;
    int          seen_count = 0;
    int          waiting_count = 0;

    assign errors        = err_count;
    assign words_waiting = waiting_count;
    assign words_checked = seen_count;

    function automatic string style_word(input int idx, input logic turn_on);
        if (idx == 0)
        begin
            if (turn_on) return "\\b ";
            return "\\b0 ";
        end
        if (idx == 1)
        begin
            if (turn_on) return "\\i ";
            return "\\i0 ";
        end
        if (idx == 2)
        begin
            if (turn_on) return "\\ul ";
            return "\\ulnone ";
        end
        if (turn_on) return "\\strike ";
        return "\\strike0 ";
    endfunction

    task automatic add_byte(input logic [7:0] b);
        item_bytes.insert(item_bytes.size(), b);
    endtask

    task automatic emit_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_byte(s[i]);
        end
    endtask

    // \u, optional minus, decimal magnitude of the signed 16-bit value, then '?'
    task automatic emit_wide(input logic [15:0] cu);
        int unsigned mag;
        int          nd;
        logic [7:0]  dig [0:5];
        emit_text("\\u");
        if (cu[15])
        begin
            add_byte(8'h2D);
            mag = 32'h10000 - cu;
        end
        else
        begin
            mag = cu;
        end
        nd = 0;
        do
        begin
            dig[nd] = 8'h30 + 8'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        while (nd > 0)
        begin
            nd--;
            add_byte(dig[nd]);
        end
        add_byte(8'h3F);
    endtask

    task automatic char_bytes(input logic [15:0] cu);
        if (cu == 16'h005C)
            emit_text("\\\\");
        else if (cu == 16'h007B)
            emit_text("\\{");
        else if (cu == 16'h007D)
            emit_text("\\}");
        else if (cu == 16'h000A)
            emit_text("\\par\n");
        else if (cu == 16'h0009)
            emit_text("\\tab ");
        else if (cu >= 16'h0020 && cu <= 16'h007E)
            add_byte(cu[7:0]);
        else if (cu >= 16'h0080)
            emit_wide(cu);
        // drop other control codes and DEL
    endtask

    task automatic pack_words();
        int        pos;
        int        cnt;
        rtf_word_t w;
        pos = 0;
        while (pos < item_bytes.size())
        begin
            cnt = item_bytes.size() - pos;
            if (cnt > WORD_BYTES) cnt = WORD_BYTES;
            w.data = '0;
            for (int i = 0; i < cnt; i++)
            begin
                w.data[8*i +: 8] = item_bytes[pos + i];
            end
            w.count = 4'(cnt);
            pos += cnt;
            w.last = (pos >= item_bytes.size());
            pending_words.insert(pending_words.size(), w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_words.delete();
            run_style     = '0;
            waiting_count = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                item_bytes.delete();
                case (req_kind_t'(req_type))
                    REQ_BEGIN:
                    begin
                        for (int i = 0; i < HDR_LEN; i++)
                        begin
                            add_byte(HEADER_ROM[i]);
                        end
                        run_style = '0;
                    end
                    REQ_STYLE:
                    begin
                        new_style = {strike_on, underline_on, italic_on, bold_on};
                        for (int i = 0; i < 4; i++)
                        begin
                            if (new_style[i] != run_style[i])
                                emit_text(style_word(i, new_style[i]));
                        end
                        run_style = new_style;
                    end
                    REQ_CHAR:
                        char_bytes(code_unit);
                    default:
                        add_byte(8'h7D);
                endcase
                pack_words();
            end

            if (res_valid && res_ready)
            begin
                seen_count++;
                if (pending_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %h count %0d last %0b",
                             $time, out_bytes, byte_count, last_of_item);
                    err_count++;
                end
                else
                begin
                    oldest = pending_words.pop_front();
                    if (out_bytes !== oldest.data)
                    begin
                        $display("%0t: out_bytes mismatch, expected %h, got %h",
                                 $time, oldest.data, out_bytes);
                        err_count++;
                    end
                    if (byte_count !== oldest.count)
                    begin
                        $display("%0t: byte_count mismatch, expected %0d, got %0d",
                                 $time, oldest.count, byte_count);
                        err_count++;
                    end
                    if (last_of_item !== oldest.last)
                    begin
                        $display("%0t: last_of_item mismatch, expected %0b, got %0b",
                                 $time, oldest.last, last_of_item);
                        err_count++;
                    end
                end
            end
            waiting_count = pending_words.size();
        end
    end

endmodule

// ===== test/rtf_styled_text_encoder_top_test.sv =====
module rtf_styled_text_encoder_top_test;
    import rtfe_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 12;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  req_type;
    logic [15:0] code_unit;
    logic        bold_on;
    logic        italic_on;
    logic        underline_on;
    logic        strike_on;
    logic        res_valid;
    logic        res_ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_item;

    int errors;
    int words_waiting;
    int words_checked;

    int   send_gap;
    int   recv_gap;
    logic hold_req;
    logic hold_done;
    int   items_sent;

    rtf_styled_text_encoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .code_unit    (code_unit),
        .bold_on      (bold_on),
        .italic_on    (italic_on),
        .underline_on (underline_on),
        .strike_on    (strike_on),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_bytes    (out_bytes),
        .byte_count   (byte_count),
        .last_of_item (last_of_item)
    );

    rtf_byte_stream_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .code_unit     (code_unit),
        .bold_on       (bold_on),
        .italic_on     (italic_on),
        .underline_on  (underline_on),
        .strike_on     (strike_on),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .out_bytes     (out_bytes),
        .byte_count    (byte_count),
        .last_of_item  (last_of_item),
        .errors        (errors),
        .words_waiting (words_waiting),
        .words_checked (words_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    // Output side: random back-pressure, plus one long hold-off on request
    initial
    begin
        res_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                res_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            res_ready = ($urandom_range(0, 99) >= recv_gap);
        end
    end

    // Offer one transaction and hold it until accepted; returns at a falling edge
    task automatic send_item(input req_kind_t kind, input logic [15:0] cu,
                             input logic [3:0] flags);
        while ($urandom_range(0, 99) < send_gap)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid    = 1'b1;
        req_type     = kind;
        code_unit    = cu;
        bold_on      = flags[0];
        italic_on    = flags[1];
        underline_on = flags[2];
        strike_on    = flags[3];
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Mostly document-shaped traffic; unused fields always carry noise
    task automatic send_random_item();
        int          pick;
        logic [15:0] cu;
        logic [3:0]  flags;
        req_kind_t   kind;
        pick  = $urandom_range(0, 99);
        cu    = 16'($urandom);
        flags = 4'($urandom);
        if (pick < 5)
            kind = REQ_BEGIN;
        else if (pick < 10)
            kind = REQ_END;
        else if (pick < 30)
            kind = REQ_STYLE;
        else
        begin
            kind = REQ_CHAR;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                cu = 16'($urandom_range(16'h0020, 16'h007E));
            else if (pick < 60)
            begin
                case ($urandom_range(0, 4))
                    0: cu = 16'h005C;
                    1: cu = 16'h007B;
                    2: cu = 16'h007D;
                    3: cu = 16'h000A;
                    default: cu = 16'h0009;
                endcase
            end
            else if (pick < 68)
                cu = ($urandom_range(0, 9) == 0) ? 16'h007F : 16'($urandom_range(0, 31));
        end
        send_item(kind, cu, flags);
    endtask

    // Stop offering until every expected word is back, then cover in-flight empty items
    task automatic drain();
        req_valid = 1'b0;
        wait (words_waiting == 0);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_type     = REQ_BEGIN;
        code_unit    = '0;
        bold_on      = 1'b0;
        italic_on    = 1'b0;
        underline_on = 1'b0;
        strike_on    = 1'b0;
        hold_req     = 1'b0;
        send_gap     = 23;
        recv_gap     = 87;
        items_sent   = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(REQ_BEGIN, 16'hFFFF, 4'hF);
        send_item(REQ_STYLE, 16'hFFFF, 4'hF);
        send_item(REQ_STYLE, 16'h0000, 4'hF);   // same flags: no bytes
        send_item(REQ_STYLE, 16'hFFFF, 4'h0);
        send_item(REQ_STYLE, 16'h0000, 4'h5);
        send_item(REQ_STYLE, 16'h0000, 4'hA);
        send_item(REQ_CHAR,  16'h0000, 4'hF);
        send_item(REQ_CHAR,  16'h0009, 4'hF);
        send_item(REQ_CHAR,  16'h000A, 4'h0);
        send_item(REQ_CHAR,  16'h001F, 4'hF);
        send_item(REQ_CHAR,  16'h0020, 4'h0);
        send_item(REQ_CHAR,  16'h0041, 4'hF);
        send_item(REQ_CHAR,  16'h005C, 4'h0);
        send_item(REQ_CHAR,  16'h007B, 4'hF);
        send_item(REQ_CHAR,  16'h007D, 4'h0);
        send_item(REQ_CHAR,  16'h007E, 4'hF);
        send_item(REQ_CHAR,  16'h007F, 4'h0);
        send_item(REQ_CHAR,  16'h0080, 4'hF);
        send_item(REQ_CHAR,  16'h7FFF, 4'h0);
        send_item(REQ_CHAR,  16'h8000, 4'hF);
        send_item(REQ_CHAR,  16'hFFFF, 4'h0);
        send_item(REQ_END,   16'hFFFF, 4'hF);
        send_item(REQ_STYLE, 16'h0000, 4'h3);
        // new document without a closing brace must forget the open style
        send_item(REQ_BEGIN, 16'h0000, 4'h0);
        send_item(REQ_STYLE, 16'h0000, 4'h3);
        drain();

        repeat (45) send_random_item();
        drain();

        send_gap = 87;
        recv_gap = 23;
        repeat (50) send_random_item();
        drain();

        send_gap = 0;
        recv_gap = 0;
        hold_req = 1'b1;
        repeat (45) send_random_item();
        req_valid = 1'b0;

        wait (words_waiting == 0);
        repeat (20) @(posedge clk);
        $display("Sent %0d transactions (headers, style runs, escapes, wide chars, ends),",
                 items_sent);
        $display("checked %0d result words under three idle mixes and one long output stall.",
                 words_checked);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== rtf_styled_text_encoder_top.f =====
design/rtfe_pkg.sv
design/rtfe_front.sv
design/rtfe_format.sv
design/rtfe_packer.sv
design/rtf_styled_text_encoder_top.sv
test/rtf_byte_stream_checker.sv
test/rtf_styled_text_encoder_top_test.sv
